// File: hdl/kdq_pkg.sv
// kdq_pkg: shared types and constants for the keyed descriptor queue
// no dependencies; imported by the interfaces and every module of the block
package kdq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int HANDLE_W    = 4;
    localparam int TOTAL_W     = 5;
    localparam int WORD_W      = 32;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FIND  = 2'd2,
        OP_ERASE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        op_t                        req_type;
        logic signed [WORD_W-1:0]   key;
        logic signed [WORD_W-1:0]   desc_a;
        logic        [WORD_W-1:0]   size_a;
        logic signed [WORD_W-1:0]   desc_b;
        logic        [WORD_W-1:0]   size_b;
        logic        [HANDLE_W-1:0] target_slot;
    } req_t;

    typedef struct packed {
        status_t                    status;
        logic                       is_empty;
        logic        [TOTAL_W-1:0]  entry_total;
        logic        [HANDLE_W-1:0] slot_handle;
        logic signed [WORD_W-1:0]   out_key;
        logic signed [WORD_W-1:0]   out_desc_a;
        logic        [WORD_W-1:0]   out_size_a;
        logic signed [WORD_W-1:0]   out_desc_b;
        logic        [WORD_W-1:0]   out_size_b;
    } rsp_t;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] desc_a;
        logic [WORD_W-1:0] size_a;
        logic [WORD_W-1:0] desc_b;
        logic [WORD_W-1:0] size_b;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    push_commit;
        logic    pop_commit;
        logic    walk_advance;
        logic    erase_commit;
        logic    find_hit;
        logic    set_status;
        status_t status_code;
        logic    rd_issue;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic key_hit;
        logic slot_hit;
        logic walk_end;
        logic target_live;
    } sts_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_READ,
        S_RESP
    } state_t;

endpackage

// File: hdl/kdq_ifs.sv
// kdq_req_if / kdq_rsp_if: valid-ready channels for requests and results
// depends on kdq_pkg for the payload types
interface kdq_req_if import kdq_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kdq_rsp_if import kdq_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/kdq_ctrl.sv
// kdq_ctrl: sequencer for push, pop, find and erase
// depends on kdq_pkg; drives commands into kdq_dpath and reads its status
module kdq_ctrl import kdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    logic walk_stop;

    assign walk_stop = (sts.op == OP_FIND && sts.key_hit) ||
                       (sts.op == OP_ERASE && sts.slot_hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.op)
                    OP_FIND:  state_next = S_WALK;
                    OP_ERASE: state_next = sts.target_live ? S_WALK : S_READ;
                    default:  state_next = S_READ;
                endcase
            end
            S_WALK:
            begin
                if (sts.walk_end || walk_stop)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        req_ready   = 1'b0;
        rsp_valid   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_EXEC:
            begin
                case (sts.op)
                    OP_PUSH:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STS_FULL;
                        end
                        else
                        begin
                            cmd.push_commit = 1'b1;
                        end
                    end
                    OP_POP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STS_EMPTY;
                        end
                        else
                        begin
                            cmd.pop_commit = 1'b1;
                        end
                    end
                    OP_ERASE:
                    begin
                        if (!sts.target_live)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WALK:
            begin
                if (sts.walk_end)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STS_NOT_FOUND;
                end
                else if (sts.op == OP_FIND && sts.key_hit)
                begin
                    cmd.find_hit = 1'b1;
                end
                else if (sts.op == OP_ERASE && sts.slot_hit)
                begin
                    cmd.erase_commit = 1'b1;
                end
                else
                begin
                    cmd.walk_advance = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            S_RESP:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: hdl/kdq_dpath.sv
// kdq_dpath: slot storage, link chain, free-slot pick, walk pointer, result regs
// depends on kdq_pkg; sequenced by kdq_ctrl through cmd_t
module kdq_dpath import kdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req_data,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp_data
);

    // storage, no reset: data from slots not in use is never reported
    entry_t            mem [QUEUE_DEPTH];
    logic [WORD_W-1:0] key_tag [QUEUE_DEPTH];
    logic [SLOT_W-1:0] link_reg [QUEUE_DEPTH];

    req_t              req_reg;
    entry_t            mem_q_reg;
    status_t           status_reg;
    logic              have_reg;
    logic [SLOT_W-1:0] rep_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic [SLOT_W-1:0] prev_reg;
    logic [CNT_W-1:0]  idx_reg;

    logic [SLOT_W-1:0]      head_reg, head_next;
    logic [SLOT_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [QUEUE_DEPTH-1:0] in_use_reg, in_use_next;

    logic [SLOT_W-1:0] free_slot;
    logic [SLOT_W-1:0] link_cur;
    logic [SLOT_W-1:0] tgt;
    logic              tgt_in_range;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [SLOT_W-1:0] link_wdata;
    logic [SLOT_W-1:0] rd_addr;
    entry_t            wr_entry;

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign link_cur     = link_reg[cur_reg];
    assign tgt          = SLOT_W'(req_reg.target_slot);
    assign tgt_in_range = 32'(req_reg.target_slot) < 32'(QUEUE_DEPTH);

    assign sts.op          = req_reg.req_type;
    assign sts.full        = count_reg == CNT_W'(QUEUE_DEPTH);
    assign sts.empty       = count_reg == '0;
    assign sts.key_hit     = key_tag[cur_reg] == $unsigned(req_reg.key);
    assign sts.slot_hit    = cur_reg == tgt;
    assign sts.walk_end    = idx_reg >= count_reg;
    assign sts.target_live = tgt_in_range && in_use_reg[tgt] && (count_reg != '0);

    assign wr_entry.key    = $unsigned(req_reg.key);
    assign wr_entry.desc_a = $unsigned(req_reg.desc_a);
    assign wr_entry.size_a = req_reg.size_a;
    assign wr_entry.desc_b = $unsigned(req_reg.desc_b);
    assign wr_entry.size_b = req_reg.size_b;

    assign rd_addr = (req_reg.req_type == OP_FIND) ? rep_reg : head_reg;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        in_use_next = in_use_reg;
        link_we     = 1'b0;
        link_waddr  = tail_reg;
        link_wdata  = free_slot;
        if (cmd.push_commit)
        begin
            in_use_next[free_slot] = 1'b1;
            count_next             = count_reg + CNT_W'(1);
            tail_next              = free_slot;
            if (count_reg == '0)
            begin
                head_next = free_slot;
            end
            else
            begin
                link_we = 1'b1;
            end
        end
        else if (cmd.pop_commit)
        begin
            // walk pointer was loaded with the head
            in_use_next[head_reg] = 1'b0;
            count_next            = count_reg - CNT_W'(1);
            head_next             = link_cur;
        end
        else if (cmd.erase_commit)
        begin
            in_use_next[tgt] = 1'b0;
            count_next       = count_reg - CNT_W'(1);
            if (idx_reg == '0)
            begin
                head_next = link_cur;
            end
            else
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = link_cur;
                if (tgt == tail_reg)
                begin
                    tail_next = prev_reg;
                end
            end
        end
        if (count_next == '0)
        begin
            head_next = '0;
            tail_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            in_use_reg <= '0;
            status_reg <= STS_OK;
            have_reg   <= 1'b0;
            rep_reg    <= '0;
            cur_reg    <= '0;
            prev_reg   <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            in_use_reg <= in_use_next;
            if (cmd.load)
            begin
                cur_reg    <= head_reg;
                prev_reg   <= head_reg;
                idx_reg    <= '0;
                status_reg <= STS_OK;
                have_reg   <= 1'b0;
            end
            if (cmd.walk_advance)
            begin
                prev_reg <= cur_reg;
                cur_reg  <= link_cur;
                idx_reg  <= idx_reg + CNT_W'(1);
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
            if (cmd.find_hit)
            begin
                have_reg <= 1'b1;
                rep_reg  <= cur_reg;
            end
            // every op but find reports the head left behind
            if (cmd.rd_issue && req_reg.req_type != OP_FIND)
            begin
                have_reg <= count_reg != '0;
                rep_reg  <= head_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_data;
        end
        if (cmd.push_commit)
        begin
            mem[free_slot]     <= wr_entry;
            key_tag[free_slot] <= wr_entry.key;
        end
        if (link_we)
        begin
            link_reg[link_waddr] <= link_wdata;
        end
        if (cmd.rd_issue)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    assign rsp_data.status      = status_reg;
    assign rsp_data.is_empty    = count_reg == '0;
    assign rsp_data.entry_total = TOTAL_W'(count_reg);
    assign rsp_data.slot_handle = have_reg ? HANDLE_W'(rep_reg) : '0;
    assign rsp_data.out_key     = have_reg ? $signed(mem_q_reg.key) : '0;
    assign rsp_data.out_desc_a  = have_reg ? $signed(mem_q_reg.desc_a) : '0;
    assign rsp_data.out_size_a  = have_reg ? mem_q_reg.size_a : '0;
    assign rsp_data.out_desc_b  = have_reg ? $signed(mem_q_reg.desc_b) : '0;
    assign rsp_data.out_size_b  = have_reg ? mem_q_reg.size_b : '0;

endmodule

// File: hdl/keyed_descriptor_queue_unit.sv
// keyed_descriptor_queue_unit: one request at a time; an accepted request passes through
// exec, then a walk along the link chain for find and for an erase of a live target slot,
// then read and response; push and pop go straight from exec to read
// next request is taken the cycle after the result beat is taken
// reset: queue empty, head/tail/count cleared; entry storage is left as is, no clear pass
// depends on kdq_pkg, kdq_ifs, kdq_ctrl, kdq_dpath
module keyed_descriptor_queue_unit import kdq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    kdq_req_if.sink         req,
    kdq_rsp_if.source       rsp
);

    cmd_t cmd;
    sts_t sts;

    kdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kdq_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp_data (rsp.data)
    );

    // a push only commits when there is room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_commit |-> !sts.full)
        else $error("push committed into a full queue");

    // a pop only commits on a non-empty queue
    a_pop_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_commit |-> !sts.empty)
        else $error("pop committed on an empty queue");

    // erase unlinks only the target slot found within the queued entries
    a_erase_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.erase_commit |-> sts.slot_hit && !sts.walk_end && sts.op == OP_ERASE)
        else $error("erase committed off target");

    // no new request while a result beat is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request accepted while result pending");

endmodule
